// ----- rtl/core/fdc_pkg.sv -----
// fdc_pkg: shared types and constants of the fir convolution engine
// used by fdc_front, fdc_back, fdc_checker and the fir_direct_convolution top level
`default_nettype none

package fdc_pkg;

  // default store depth and fixed field widths
  localparam int unsigned FDC_MAX_TAPS = 256;
  localparam int unsigned TAP_COUNT_W  = 9;
  localparam int unsigned TAP_INDEX_W  = 8;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned FRAC_BITS    = 15;
  localparam int unsigned PROD_W       = 2 * SAMPLE_W;

  // stream payload widths, tdata padded to whole bytes
  localparam int unsigned IN_TDATA_W  = ((TAP_INDEX_W + SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W  = ACTION_W;
  localparam int unsigned OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 1;

  // action codes carried on the input tuser
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_TAP    = 2'd0,
    ACT_PUSH_SAMPLE = 2'd1,
    ACT_PUSH_ZERO   = 2'd2,
    ACT_CLEAR       = 2'd3
  } action_e;

  // classified operations handed from front to back
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PUSH,
    OP_CLEAR
  } op_kind_e;

  typedef struct packed {
    op_kind_e                      kind;
    logic [TAP_INDEX_W-1:0]        tap_index;
    logic signed [SAMPLE_W-1:0]    value;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_req_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_MAC,
    BS_OUT
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/core/fdc_ram.sv -----
// fdc_ram: generic single write port, single read port ram, registered read
// standalone, no package dependency
`default_nettype none

module fdc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/fdc_front.sv -----
// fdc_front: accepts input words, classifies them into operations and queues them
// depends on fdc_pkg
`default_nettype none

module fdc_front #(
  parameter int unsigned MAX_TAPS = fdc_pkg::FDC_MAX_TAPS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // [7:0] tap_index, [23:8] value
  input  wire logic [fdc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [1:0] action
  input  wire logic [fdc_pkg::IN_TUSER_W-1:0] s_axis_tuser,
  output      fdc_pkg::op_req_t               req_o,
  input  wire logic                          pop_i
);

  import fdc_pkg::*;

  localparam int unsigned QDEPTH = 2;

  op_t                    queue_q [QDEPTH];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             count_q, count_d;
  logic                   accept;
  logic                   keep;
  logic                   push;
  logic                   pop;
  op_t                    op_in;
  logic [TAP_INDEX_W-1:0] in_tap_index;
  logic [SAMPLE_W-1:0]    in_value;
  action_e                in_action;

  // unpack the word
  assign in_tap_index = s_axis_tdata[TAP_INDEX_W-1:0];
  assign in_value     = s_axis_tdata[TAP_INDEX_W +: SAMPLE_W];
  assign in_action    = action_e'(s_axis_tuser[ACTION_W-1:0]);

  assign s_axis_tready = (count_q != 2'(QDEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  // classify: out of range loads are dropped, zero pushes become pushes of zero
  always_comb begin
    keep            = 1'b1;
    op_in.kind      = OP_PUSH;
    op_in.tap_index = in_tap_index;
    op_in.value     = $signed(in_value);
    case (in_action)
      ACT_LOAD_TAP: begin
        op_in.kind = OP_LOAD;
        keep       = (32'(in_tap_index) < MAX_TAPS);
      end
      ACT_PUSH_SAMPLE: begin
        op_in.kind = OP_PUSH;
      end
      ACT_PUSH_ZERO: begin
        op_in.kind  = OP_PUSH;
        op_in.value = '0;
      end
      ACT_CLEAR: begin
        op_in.kind = OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;
  assign pop  = pop_i && (count_q != 2'd0);

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op_in;
    end
  end

  assign req_o.valid = (count_q != 2'd0);
  assign req_o.op    = queue_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- rtl/core/fdc_back.sv -----
// fdc_back: executes queued operations, runs the multiply-accumulate loop over
// the tap and history rams and holds the output word; depends on fdc_pkg, fdc_ram
`default_nettype none

module fdc_back #(
  parameter int unsigned MAX_TAPS = fdc_pkg::FDC_MAX_TAPS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fdc_pkg::op_req_t                req_i,
  output      logic                            pop_o,
  input  wire logic [fdc_pkg::TAP_COUNT_W-1:0] tap_count_i,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [15:0] output_sample
  output      logic [fdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] saturated
  output      logic [fdc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  import fdc_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_TAPS);
  localparam int unsigned CW    = $clog2(MAX_TAPS + 1);
  localparam int unsigned ACC_W = PROD_W + CW;
  localparam int unsigned SH_W  = ACC_W - FRAC_BITS;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-(1 << (SAMPLE_W - 1)));

  back_state_e                state_q, state_d;
  logic [AW-1:0]              ptr_q, ptr_d, ptr_next;
  logic [CW-1:0]              fill_q, fill_d, fill_inc;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [CW-1:0]              k_q, k_d;
  logic [AW-1:0]              idx_q, idx_d;
  logic [CW-1:0]              taps_used;
  logic [CW-1:0]              mac_len;
  logic                       issue;
  logic                       rd_v_q;
  logic                       mul_v_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] tap_rd;
  logic signed [SAMPLE_W-1:0] hist_rd;
  logic                       tap_we;
  logic                       hist_we;
  logic                       start_push;
  logic                       out_load;
  logic signed [SH_W-1:0]     shifted;
  logic                       sat_hi;
  logic                       sat_lo;
  logic [SAMPLE_W-1:0]        res_sample;
  logic                       out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]        out_sample_q;
  logic                       out_sat_q;

  // taps in use, clipped to the store depth
  assign taps_used = (32'(tap_count_i) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(tap_count_i);

  // ring pointer and samples-since-clear count after a push
  assign ptr_next = (32'(ptr_q) == MAX_TAPS - 1) ? '0 : ptr_q + AW'(1);
  assign fill_inc = (32'(fill_q) == MAX_TAPS) ? fill_q : fill_q + CW'(1);
  // history older than the fill count is zero, so those taps are skipped
  assign mac_len  = (fill_inc < taps_used) ? fill_inc : taps_used;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE: begin
        if (req_i.valid && req_i.op.kind == OP_PUSH) begin
          state_d = BS_MAC;
        end
      end
      BS_MAC: begin
        if (k_q == cnt_q && !rd_v_q && !mul_v_q) begin
          state_d = BS_OUT;
        end
      end
      BS_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o      = 1'b0;
    tap_we     = 1'b0;
    hist_we    = 1'b0;
    start_push = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      BS_IDLE: begin
        pop_o      = req_i.valid;
        tap_we     = req_i.valid && req_i.op.kind == OP_LOAD;
        hist_we    = req_i.valid && req_i.op.kind == OP_PUSH;
        start_push = hist_we;
      end
      BS_MAC: begin
        issue = (k_q != cnt_q);
      end
      BS_OUT: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // history pointer, fill count and loop counters
  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    k_d    = k_q;
    idx_d  = idx_q;
    if (pop_o && req_i.op.kind == OP_CLEAR) begin
      ptr_d  = '0;
      fill_d = '0;
    end
    if (start_push) begin
      ptr_d  = ptr_next;
      fill_d = fill_inc;
      cnt_d  = mac_len;
      k_d    = '0;
      idx_d  = ptr_next;
    end
    if (issue) begin
      k_d   = k_q + CW'(1);
      idx_d = (idx_q == '0) ? AW'(MAX_TAPS - 1) : idx_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      ptr_q   <= '0;
      fill_q  <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      idx_q   <= '0;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      idx_q   <= idx_d;
      rd_v_q  <= issue;
      mul_v_q <= rd_v_q;
    end
  end

  // coefficient store
  fdc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (AW'(req_i.op.tap_index)),
    .wdata_i (req_i.op.value),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (tap_rd)
  );

  // sample history ring
  fdc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (ptr_next),
    .wdata_i (req_i.op.value),
    .raddr_i (idx_q),
    .rdata_o (hist_rd)
  );

  // product register and accumulator
  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= tap_rd * hist_rd;
    end
    if (start_push) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // floor shift and saturation
  always_comb begin
    shifted = SH_W'(acc_q >>> FRAC_BITS);
    sat_hi  = (shifted > SAT_HI);
    sat_lo  = (shifted < SAT_LO);
    if (sat_hi) begin
      res_sample = SAT_HI[SAMPLE_W-1:0];
    end else if (sat_lo) begin
      res_sample = SAT_LO[SAMPLE_W-1:0];
    end else begin
      res_sample = shifted[SAMPLE_W-1:0];
    end
  end

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= res_sample;
      out_sat_q    <= sat_hi || sat_lo;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_sample_q);
  assign m_axis_tuser  = OUT_TUSER_W'(out_sat_q);

endmodule

`default_nettype wire

// ----- rtl/core/fir_direct_convolution.sv -----
// a sample or zero push gives its output word after the back end pops it, writes the history
// and runs one multiply-accumulate per tap over n taps, where n = min(tap_count, samples
// since last clear); the push holds the back end for that loop plus any output stall, while
// the front queue takes up to two more words; loads and clears give no word
// reset is asynchronous active low: history reads as zero through a fill count,
// no clearing pass; the coefficient store holds no defined value until loaded
`default_nettype none

module fir_direct_convolution #(
  parameter int unsigned MAX_TAPS = fdc_pkg::FDC_MAX_TAPS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // [7:0] tap_index, [23:8] value
  input  wire logic [fdc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] action
  input  wire logic [fdc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  // output stream
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [15:0] output_sample
  output      logic [fdc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] saturated
  output      logic [fdc_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  // tap_count write channel
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [fdc_pkg::TAP_COUNT_W-1:0]  cfg_data_i
);

  import fdc_pkg::*;

  logic [TAP_COUNT_W-1:0] tap_count_q;
  op_req_t                req;
  logic                   pop;

  // tap_count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_W'(MAX_TAPS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      tap_count_q <= cfg_data_i;
    end
  end

  fdc_front #(
    .MAX_TAPS (MAX_TAPS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_o         (req),
    .pop_i         (pop)
  );

  fdc_back #(
    .MAX_TAPS (MAX_TAPS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .pop_o         (pop),
    .tap_count_i   (tap_count_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/core/fdc_checker.sv -----
// fdc_checker: port level checks of the fir convolution engine, bound to the top
// depends on fdc_pkg
`default_nettype none

module fdc_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  // [15:0] output_sample
  input wire logic [fdc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] saturated
  input wire logic [fdc_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

  import fdc_pkg::*;

  // a stalled output word stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // a stalled output word keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // the saturation flag only comes with a clipped value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[SAMPLE_W-1:0] == 16'h7fff || m_axis_tdata[SAMPLE_W-1:0] == 16'h8000)
    else $error("saturation flag without a clipped value");

  // reset empties the output register
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output word valid after reset");

endmodule

bind fir_direct_convolution fdc_checker u_fdc_checker (.*);

`default_nettype wire
